>>> rtl/mrs_pkg.sv
// shared types and constants for the morus-1280 aead core
// no dependencies
package mrs_pkg;
   localparam logic [2:0] REQ_INIT = 3'd0;
   localparam logic [2:0] REQ_AD   = 3'd1;
   localparam logic [2:0] REQ_ENC  = 3'd2;
   localparam logic [2:0] REQ_DEC  = 3'd3;
   localparam logic [2:0] REQ_FIN  = 3'd4;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_K256 = 3'd4;

   localparam logic [63:0] MORUS_C0 = 64'h0d08050302010100;
   localparam logic [63:0] MORUS_C1 = 64'h6279e99059372215;
   localparam logic [63:0] MORUS_C2 = 64'hf12fc26d55183ddb;
   localparam logic [63:0] MORUS_C3 = 64'hdd28b57342311120;

   typedef logic [255:0] row_type;
   typedef row_type [4:0] state_type;

   typedef struct packed {
      logic load_init;   // load nonce and key rows
      logic load_fin;    // row4 ^= row0
      logic update;      // one state update with dp message
      logic msg_sel;     // 0 zero message, 1 working message
      logic key_xor;     // row1 ^= key
      logic block;       // one data block step
      logic tag_out;     // write tag to row 0 and result
      logic cnt_clr;
   } cmd_type;

   function automatic logic [63:0] byte_mask(input logic [5:0] n, input int w);
      logic [6:0] b;
      b = {1'b0, n} - 7'(8 * w);
      if (n <= 6'(8 * w)) return 64'd0;
      if (b >= 7'd8) return '1;
      return (64'd1 << {b[2:0], 3'b000}) - 64'd1;
   endfunction

   function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic row_type rnd(input row_type a, input row_type b, input row_type c,
                                   input row_type d, input row_type m, input int r);
      row_type o;
      logic [63:0] v;
      for (int i = 0; i < 4; i++) begin
         v = a[64*i +: 64] ^ d[64*i +: 64] ^ (b[64*i +: 64] & c[64*i +: 64]) ^ m[64*i +: 64];
         o[64*i +: 64] = rotl(v, r);
      end
      return o;
   endfunction

   // new word i takes old word (i + k) mod 4
   function automatic row_type wrot(input row_type x, input int k);
      row_type o;
      for (int i = 0; i < 4; i++) o[64*i +: 64] = x[64*((i + k) % 4) +: 64];
      return o;
   endfunction
endpackage

>>> rtl/mrs_req_if.sv
// request and response channel interfaces
// depends on nothing
interface mrs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [63:0] data_word0;
   logic [63:0] data_word1;
   logic [63:0] data_word2;
   logic [63:0] data_word3;
   logic [5:0]  valid_bytes;
   logic        check_tag;
   modport source (output valid, req_type, data_word0, data_word1, data_word2,
                   data_word3, valid_bytes, check_tag, input ready);
   modport sink (input valid, req_type, data_word0, data_word1, data_word2,
                 data_word3, valid_bytes, check_tag, output ready);
endinterface

interface mrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_word0;
   logic [63:0] out_word1;
   logic [63:0] out_word2;
   logic [63:0] out_word3;
   logic [5:0]  out_valid_bytes;
   logic        tag_ok;
   modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                   out_valid_bytes, tag_ok, input ready);
   modport sink (input valid, out_word0, out_word1, out_word2, out_word3,
                 out_valid_bytes, tag_ok, output ready);
endinterface

>>> rtl/morus1280_aead_core.sv
// morus-1280 aead core top level
// a block result is registered and valid in the cycle after the block is accepted
// throughput: one block per cycle when the result side keeps up
// the update round logic is one full five-round update per cycle
// init runs 16 updates, the last one fused with the key xor sequencing
// reset: synchronous active high, clears state, counters and key registers
module morus1280_aead_core (
   input  logic        clock,
   input  logic        reset,
   mrs_req_if.sink     req,
   mrs_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import mrs_pkg::*;

   logic [63:0] k0_ff, k1_ff, k2_ff, k3_ff;
   logic        k256_ff, zr;
   cmd_type     cmd, cmd_dp;
   logic [255:0] key, rd;
   logic [5:0]  rn, nb;
   logic        ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         k0_ff <= '0; k1_ff <= '0; k2_ff <= '0; k3_ff <= '0; k256_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY0: k0_ff <= csr_wdata;
            CSR_KEY1: k1_ff <= csr_wdata;
            CSR_KEY2: k2_ff <= csr_wdata;
            CSR_KEY3: k3_ff <= csr_wdata;
            CSR_K256: k256_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign key = {k256_ff ? k3_ff : k1_ff, k256_ff ? k2_ff : k0_ff, k1_ff, k0_ff};
   assign nb = (req.valid_bytes > 6'd32) ? 6'd32 : req.valid_bytes;

   mrs_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .req_type(req.req_type), .nbytes(nb),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd, .zero_res(zr)
   );

   // last init round updates and xors the key in one step
   always_comb begin
      cmd_dp = cmd;
      if (cmd.key_xor) cmd_dp.update = 1'b1;
   end

   mrs_datapath u_dp (
      .clock, .reset, .cmd(cmd_dp),
      .req_type(req.req_type),
      .data({req.data_word3, req.data_word2, req.data_word1, req.data_word0}),
      .nbytes(nb), .check_tag(req.check_tag), .key,
      .res_data(rd), .res_n(rn), .res_ok(ok)
   );

   assign rsp.out_word0 = zr ? '0 : rd[63:0];
   assign rsp.out_word1 = zr ? '0 : rd[127:64];
   assign rsp.out_word2 = zr ? '0 : rd[191:128];
   assign rsp.out_word3 = zr ? '0 : rd[255:192];
   assign rsp.out_valid_bytes = zr ? '0 : rn;
   assign rsp.tag_ok = zr ? 1'b0 : ok;
endmodule

>>> rtl/mrs_datapath.sv
// state register, update round logic, counters and result register
// depends on mrs_pkg
module mrs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mrs_pkg::cmd_type    cmd,
   input  logic [2:0]          req_type,
   input  logic [255:0]        data,
   input  logic [5:0]          nbytes,
   input  logic                check_tag,
   input  logic [255:0]        key,
   output logic [255:0]        res_data,
   output logic [5:0]          res_n,
   output logic                res_ok
);
   import mrs_pkg::*;

   state_type   s_ff, s_in, su;
   logic [63:0] adc_ff, adc_in, mc_ff, mc_in;
   row_type     m_ff, m_in, blk, ks, res, um, r0, r1, t0, t1, t2, t3, t4;
   logic [255:0] rd_ff, rd_in;
   logic [127:0] tg_ff, tg_in;
   logic [5:0]  rn_ff, rn_in;
   logic        ok_ff, ok_in, ck_ff, ck_in, dec;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         blk[64*i +: 64] = data[64*i +: 64] & byte_mask(nbytes, i);
         ks[64*i +: 64] = s_ff[0][64*i +: 64] ^ s_ff[1][64*(((i + 1) % 4)) +: 64]
                          ^ (s_ff[2][64*i +: 64] & s_ff[3][64*i +: 64]);
         res[64*i +: 64] = (blk[64*i +: 64] ^ ks[64*i +: 64]) & byte_mask(nbytes, i);
      end
      dec = (req_type == REQ_DEC);
   end

   // message feeding this cycle's update
   always_comb begin
      if (cmd.block) um = dec ? res : blk;
      else if (cmd.msg_sel) um = m_ff;
      else um = '0;
   end

   always_comb begin
      r0 = rnd(s_ff[0], s_ff[1], s_ff[2], s_ff[3], '0, 13);
      t0 = wrot(r0, 1);
      t3 = wrot(s_ff[3], 3);
      t1 = rnd(s_ff[1], s_ff[2], t3, s_ff[4], um, 46);
      t4 = wrot(s_ff[4], 2);
      t2 = rnd(s_ff[2], t3, t4, r0, um, 38);
      r1 = wrot(t1, 2);
      su[3] = rnd(t3, t4, t0, t1, um, 7);
      su[4] = rnd(t4, t0, r1, t2, um, 4);
      su[2] = wrot(t2, 3);
      su[0] = t0;
      su[1] = r1;
   end

   always_comb begin
      s_in = s_ff; adc_in = adc_ff; mc_in = mc_ff; m_in = m_ff;
      rd_in = rd_ff; rn_in = rn_ff; ok_in = ok_ff;
      tg_in = tg_ff; ck_in = ck_ff;
      if (cmd.load_init) begin
         s_in[0] = {128'd0, data[127:0]};
         s_in[1] = key;
         s_in[2] = '1;
         s_in[3] = '0;
         s_in[4] = {MORUS_C3, MORUS_C2, MORUS_C1, MORUS_C0};
         rd_in = '0; rn_in = '0; ok_in = 1'b0;
      end
      if (cmd.load_fin) begin
         s_in[4] = s_ff[4] ^ s_ff[0];
         m_in = {128'd0, mc_ff << 3, adc_ff << 3};
         tg_in = data[127:0];
         ck_in = check_tag;
      end
      if (cmd.update) s_in = su;
      if (cmd.key_xor) s_in[1] = s_in[1] ^ key;
      if (cmd.cnt_clr) begin
         adc_in = '0; mc_in = '0;
      end
      if (cmd.block) begin
         rd_in = '0; rn_in = '0; ok_in = 1'b0;
         if (nbytes != 6'd0) begin
            if (req_type == REQ_AD) adc_in = adc_ff + 64'(nbytes);
            else begin
               mc_in = mc_ff + 64'(nbytes);
               rd_in = res; rn_in = nbytes;
            end
         end
      end
      if (cmd.tag_out) begin
         s_in[0][127:0] = ks[127:0];
         rd_in = {128'd0, ks[127:0]};
         rn_in = 6'd16;
         ok_in = ck_ff && (tg_ff == ks[127:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0; adc_ff <= '0; mc_ff <= '0;
      end else begin
         s_ff <= s_in; adc_ff <= adc_in; mc_ff <= mc_in;
      end
      m_ff <= m_in; rd_ff <= rd_in; rn_ff <= rn_in; ok_ff <= ok_in;
      tg_ff <= tg_in; ck_ff <= ck_in;
   end

   assign res_data = rd_ff;
   assign res_n = rn_ff;
   assign res_ok = ok_ff;
endmodule

>>> rtl/mrs_ctrl.sv
// request sequencer: counts update rounds and runs the result handshake
// depends on mrs_pkg
module mrs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [2:0]       req_type,
   input  logic [5:0]       nbytes,
   output logic             out_valid,
   input  logic             out_ready,
   output mrs_pkg::cmd_type cmd,
   output logic             zero_res
);
   import mrs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INIT = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_TAG  = 2'd3;

   logic [1:0] st_ff, st_in;
   logic [4:0] rc_ff, rc_in;
   logic       ov_ff, ov_in, zr_ff, zr_in, acc;

   assign in_ready = (st_ff == ST_IDLE) && (!ov_ff || out_ready);
   assign acc = in_valid && in_ready;

   always_comb begin
      st_in = st_ff; rc_in = rc_ff; zr_in = zr_ff;
      ov_in = ov_ff && !out_ready;
      cmd = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               zr_in = 1'b0;
               unique case (req_type)
                  REQ_INIT: begin
                     cmd.load_init = 1'b1; cmd.cnt_clr = 1'b1;
                     rc_in = 5'd0; st_in = ST_INIT;
                  end
                  REQ_AD, REQ_ENC, REQ_DEC: begin
                     cmd.block = 1'b1;
                     cmd.update = (nbytes != 6'd0);
                     ov_in = 1'b1;
                  end
                  REQ_FIN: begin
                     cmd.load_fin = 1'b1; rc_in = 5'd0; st_in = ST_FIN;
                  end
                  default: begin
                     zr_in = 1'b1; ov_in = 1'b1;
                  end
               endcase
            end
         end
         ST_INIT: begin
            cmd.update = 1'b1;
            rc_in = rc_ff + 5'd1;
            if (rc_ff == 5'd15) begin
               cmd.update = 1'b0; cmd.key_xor = 1'b1;
               // last update merges with the key xor in the top level
            end
            if (rc_ff == 5'd15) begin
               st_in = ST_IDLE; ov_in = 1'b1;
            end
         end
         ST_FIN: begin
            cmd.update = 1'b1; cmd.msg_sel = 1'b1;
            rc_in = rc_ff + 5'd1;
            if (rc_ff == 5'd9) st_in = ST_TAG;
         end
         ST_TAG: begin
            cmd.tag_out = 1'b1; st_in = ST_IDLE; ov_in = 1'b1;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; rc_ff <= '0; ov_ff <= 1'b0; zr_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rc_ff <= rc_in; ov_ff <= ov_in; zr_ff <= zr_in;
      end
   end

   assign out_valid = ov_ff;
   assign zero_res = zr_ff;

`ifndef SYNTHESIS
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !in_ready) else $error("accept while busy");
   a_ov_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> ov_ff) else $error("result dropped");
   a_init_len: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_INIT) |-> (rc_ff <= 5'd15)) else $error("init overrun");
`endif
endmodule

>>> dv/testbench.sv
// self-checking testbench for the morus-1280 aead core
// depends on mrs_pkg, the channel interfaces and the core in rtl
`timescale 1ns / 100ps

module testbench;
   import mrs_pkg::*;

   localparam int LIMIT = 400000;
   localparam int REQ_BAD = 5;
   localparam int REQ_BAD_HI = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   mrs_req_if req ();
   mrs_rsp_if rsp ();

   morus1280_aead_core DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [63:0] w0, w1, w2, w3;
      logic [5:0]  nb;
      logic        ok;
   } cipher_out_type;

   logic [63:0] st [20];
   logic [63:0] ad_cnt, msg_cnt;
   logic [63:0] kw [4];
   logic        k256;
   cipher_out_type expected_q [$];
   int errors = 0, checked = 0, sent = 0, cycles = 0, hold = 0;
   int n_init = 0, n_fin = 0;

   function automatic logic [63:0] rl(logic [63:0] x, int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic logic [63:0] bmask(int n, int w);
      int b;
      b = n - 8 * w;
      if (b <= 0) return 64'd0;
      if (b >= 8) return '1;
      return (64'd1 << (8 * b)) - 64'd1;
   endfunction

   task automatic row_mix(int a, int b, int c, int d, logic [63:0] m [4], int r);
      for (int i = 0; i < 4; i++)
         st[4*a+i] = rl(st[4*a+i] ^ st[4*d+i] ^ (st[4*b+i] & st[4*c+i]) ^ m[i], r);
   endtask

   task automatic word_rot(int row, int k);
      logic [63:0] t [4];
      for (int i = 0; i < 4; i++) t[i] = st[4*row + ((i + k) & 3)];
      for (int i = 0; i < 4; i++) st[4*row+i] = t[i];
   endtask

   task automatic state_update(logic [63:0] m [4]);
      logic [63:0] z [4];
      z = '{default: 64'd0};
      row_mix(0, 1, 2, 3, z, 13); word_rot(3, 3);
      row_mix(1, 2, 3, 4, m, 46); word_rot(4, 2);
      row_mix(2, 3, 4, 0, m, 38); word_rot(0, 1);
      row_mix(3, 4, 0, 1, m, 7);  word_rot(1, 2);
      row_mix(4, 0, 1, 2, m, 4);  word_rot(2, 3);
   endtask

   function automatic logic [63:0] kstream(int i);
      return st[i] ^ st[4 + ((i + 1) & 3)] ^ (st[8+i] & st[12+i]);
   endfunction

   task automatic predict_cipher(logic [2:0] rt, logic [63:0] d [4], logic [5:0] vb,
                                 logic ct);
      cipher_out_type o;
      logic [63:0] blk [4], res [4], ks [4], key [4], z [4], lens [4];
      int n;
      n = (vb > 32) ? 32 : vb;
      o = '0;
      z = '{default: 64'd0};
      for (int i = 0; i < 4; i++) blk[i] = d[i] & bmask(n, i);
      if (rt == REQ_INIT) begin
         key[0] = kw[0]; key[1] = kw[1];
         key[2] = k256 ? kw[2] : kw[0];
         key[3] = k256 ? kw[3] : kw[1];
         st[0] = d[0]; st[1] = d[1]; st[2] = 0; st[3] = 0;
         for (int i = 0; i < 4; i++) begin
            st[4+i] = key[i]; st[8+i] = '1; st[12+i] = 0;
         end
         st[16] = MORUS_C0; st[17] = MORUS_C1; st[18] = MORUS_C2; st[19] = MORUS_C3;
         for (int j = 0; j < 16; j++) state_update(z);
         for (int i = 0; i < 4; i++) st[4+i] ^= key[i];
         ad_cnt = 0; msg_cnt = 0;
      end else if (rt == REQ_AD || rt == REQ_ENC || rt == REQ_DEC) begin
         if (n != 0) begin
            if (rt == REQ_AD) begin
               state_update(blk);
               ad_cnt += n;
            end else begin
               for (int i = 0; i < 4; i++) res[i] = (blk[i] ^ kstream(i)) & bmask(n, i);
               if (rt == REQ_ENC) state_update(blk);
               else state_update(res);
               msg_cnt += n;
               o.w0 = res[0]; o.w1 = res[1]; o.w2 = res[2]; o.w3 = res[3];
               o.nb = 6'(n);
            end
         end
      end else if (rt == REQ_FIN) begin
         lens[0] = ad_cnt << 3; lens[1] = msg_cnt << 3; lens[2] = 0; lens[3] = 0;
         for (int i = 0; i < 4; i++) st[16+i] ^= st[i];
         for (int j = 0; j < 10; j++) state_update(lens);
         for (int i = 0; i < 4; i++) ks[i] = kstream(i);
         st[0] = ks[0]; st[1] = ks[1];
         o.w0 = ks[0]; o.w1 = ks[1]; o.nb = 6'd16;
         o.ok = ct && d[0] == ks[0] && d[1] == ks[1];
      end
      expected_q.push_back(o);
   endtask

   initial begin
      req.valid = 1'b0; req.req_type = '0; req.data_word0 = '0; req.data_word1 = '0;
      req.data_word2 = '0; req.data_word3 = '0; req.valid_bytes = '0; req.check_tag = 1'b0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout with %0d items outstanding", expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // long result stall, counted down in cycles
   always @(posedge clock) begin
      if (hold > 0) hold <= hold - 1;
   end

   // result side: random stall per item, plus a long hold when requested
   int rsp_wait = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            cipher_out_type a, e;
            a = '{rsp.out_word0, rsp.out_word1, rsp.out_word2, rsp.out_word3,
                  rsp.out_valid_bytes, rsp.tag_ok};
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected item %p", a);
            end else begin
               e = expected_q.pop_front();
               checked++;
               if (a !== e) begin
                  errors++;
                  if (errors <= 10) $display("mismatch item %0d exp %p got %p", checked, e, a);
               end
            end
            rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) rsp_wait = 0;
         end
         if (hold > 0) begin
            rsp.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp.ready <= 1'b0;
         end else rsp.ready <= 1'b1;
      end
   end

   bit no_gaps = 0;

   task automatic send_item(logic [2:0] rt, logic [63:0] d0, d1, d2, d3,
                            logic [5:0] vb, logic ct);
      logic [63:0] d [4];
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1; req.req_type <= rt;
      req.data_word0 <= d0; req.data_word1 <= d1; req.data_word2 <= d2;
      req.data_word3 <= d3; req.valid_bytes <= vb; req.check_tag <= ct;
      d = '{d0, d1, d2, d3};
      do @(posedge clock); while (!req.ready);
      predict_cipher(rt, d, vb, ct);
      sent++;
      if (rt == REQ_INIT) n_init++;
      if (rt == REQ_FIN) n_fin++;
   endtask

   function automatic logic [63:0] r64();
      return {$urandom, $urandom};
   endfunction

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] v);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_KEY0: kw[0] = v;
         CSR_KEY1: kw[1] = v;
         CSR_KEY2: kw[2] = v;
         CSR_KEY3: kw[3] = v;
         CSR_K256: k256 = v[0];
         default: ;
      endcase
   endtask

   task automatic load_key(logic [63:0] a, b, c, e, logic big);
      write_csr(CSR_KEY0, a); write_csr(CSR_KEY1, b);
      write_csr(CSR_KEY2, c); write_csr(CSR_KEY3, e);
      write_csr(CSR_K256, {63'd0, big});
   endtask

   // one message: init, ad blocks, data blocks, finalize, tag often checked
   task automatic run_message(int n_ad, int n_msg, logic dec);
      logic [63:0] tag0, tag1;
      int vb;
      send_item(REQ_INIT, r64(), r64(), r64(), r64(), 6'($urandom_range(0, 63)),
                1'($urandom));
      for (int i = 0; i < n_ad; i++) begin
         vb = (i == n_ad - 1) ? $urandom_range(1, 32) : 32;
         send_item(REQ_AD, r64(), r64(), r64(), r64(), 6'(vb), 1'b0);
      end
      for (int i = 0; i < n_msg; i++) begin
         vb = (i == n_msg - 1) ? $urandom_range(1, 32) : 32;
         send_item(dec ? REQ_DEC : REQ_ENC, r64(), r64(), r64(), r64(), 6'(vb), 1'b0);
      end
      // predict the tag on a saved state to supply a matching one three times in four
      begin
         logic [63:0] sv [20], sa, sm;
         cipher_out_type keep [$];
         logic [63:0] zz [4];
         sv = st; sa = ad_cnt; sm = msg_cnt; keep = expected_q;
         zz = '{default: 64'd0};
         predict_cipher(REQ_FIN, zz, 6'd0, 1'b0);
         tag0 = expected_q[$].w0; tag1 = expected_q[$].w1;
         st = sv; ad_cnt = sa; msg_cnt = sm; expected_q = keep;
      end
      if ($urandom_range(0, 3) == 0) tag0 ^= 64'd1 << $urandom_range(0, 63);
      send_item(REQ_FIN, tag0, tag1, r64(), r64(), 6'($urandom_range(0, 63)),
                1'($urandom));
   endtask

   task automatic test_directed();
      load_key('0, '0, '0, '0, 1'b0);
      send_item(REQ_INIT, '0, '0, '0, '0, 6'd0, 1'b0);
      send_item(REQ_AD, '1, '1, '1, '1, 6'd32, 1'b0);
      send_item(REQ_AD, '1, '1, '1, '1, 6'd0, 1'b0);
      send_item(REQ_ENC, '1, '1, '1, '1, 6'd63, 1'b0);
      send_item(REQ_ENC, '1, '0, '1, '0, 6'd1, 1'b0);
      send_item(REQ_DEC, '1, '1, '1, '1, 6'd31, 1'b0);
      send_item(REQ_DEC, '0, '0, '0, '0, 6'd0, 1'b0);
      send_item(3'(REQ_BAD), '1, '1, '1, '1, 6'd32, 1'b1);
      send_item(3'(REQ_BAD_HI), '1, '1, '1, '1, 6'd32, 1'b1);
      send_item(REQ_FIN, '1, '1, '1, '1, 6'd32, 1'b1);
      send_item(REQ_FIN, '0, '0, '0, '0, 6'd0, 1'b0);
      send_item(REQ_ENC, r64(), r64(), r64(), r64(), 6'd17, 1'b0);
      drain();
      load_key('1, '1, '1, '1, 1'b1);
      run_message(1, 1, 1'b0);
      run_message(0, 1, 1'b1);
      drain();
   endtask

   task automatic test_random();
      for (int p = 0; p < 6; p++) begin
         load_key(r64(), r64(), r64(), r64(), 1'(p));
         while (sent < 180 * (p + 1)) begin
            if ($urandom_range(0, 9) == 0)
               send_item(3'($urandom_range(0, 7)), r64(), r64(), r64(), r64(),
                         6'($urandom_range(0, 63)), 1'($urandom));
            else
               run_message($urandom_range(0, 3), $urandom_range(0, 6), 1'($urandom));
         end
         drain();
      end
   endtask

   task automatic test_backpressure();
      load_key(r64(), r64(), '0, '0, 1'b0);
      no_gaps = 1;
      @(posedge clock);
      hold <= 300;
      for (int i = 0; i < 40; i++)
         send_item(REQ_ENC, r64(), r64(), r64(), r64(), 6'd32, 1'b0);
      no_gaps = 0;
      drain();
   endtask

   initial begin
      kw = '{default: 64'd0};
      k256 = 0;
      st = '{default: 64'd0};
      ad_cnt = 0; msg_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      $display("%0d items sent, %0d results checked, %0d inits, %0d finalizes",
               sent, checked, n_init, n_fin);
      $display("key modes 128 and 256 bits, partial blocks and long result stall covered");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/mrs_pkg.sv
rtl/mrs_req_if.sv
rtl/mrs_datapath.sv
rtl/mrs_ctrl.sv
rtl/morus1280_aead_core.sv
dv/testbench.sv
